FILE: design/tscd_pkg.sv
// Shared types and constants for the thumb-shift chord detector.
// Used by the front end, the decision engine, the result queue and the top level.
// No dependencies.
package tscd_pkg;

  typedef enum logic [2:0] {
    EV_CHAR    = 3'd0,
    EV_THUMB   = 3'd1,
    EV_REL     = 3'd2,
    EV_ALLOFF  = 3'd3,
    EV_INIT    = 3'd4,
    EV_TICK    = 3'd5,
    EV_TIMEOUT = 3'd6,
    EV_REPEAT  = 3'd7
  } ev_e;

  typedef enum logic [1:0] {
    KIND_CHORD    = 2'd0,
    KIND_THUMB    = 2'd1,
    KIND_BS_CHORD = 2'd2
  } kind_e;

  localparam logic [2:0] REG_CHAR_WAIT  = 3'd0;
  localparam logic [2:0] REG_THUMB_WAIT = 3'd1;
  localparam logic [2:0] REG_OVERLAP    = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS = 3'd3;
  localparam logic [2:0] REG_REP_DELAY  = 3'd4;
  localparam logic [2:0] REG_REP_IVAL   = 3'd5;
  localparam logic [2:0] REG_MODE       = 3'd6;

  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 40;

  typedef struct packed {
    ev_e         ev;
    logic [15:0] key;
    logic [31:0] now;
    logic        shift;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] char_code;
    logic [15:0] thumb_code;
    logic        long_press;
    logic        shift_applied;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] char_wait;
    logic [15:0] thumb_wait;
    logic [15:0] overlap;
    logic [15:0] long_press;
    logic [15:0] rep_delay;
    logic [15:0] rep_ival;
    logic [2:0]  mode;
  } cfg_t;

endpackage

FILE: design/thumb_shift_chord_detector.sv
// Thumb-shift chord detector, top level. Path: input queue, decision engine, result queue; a
// tick may also hold a word in the engine's pending register. Key events take one engine
// step each, ticks take two (time-out step, repeat step); the engine stalls while the 4-word
// result queue has fewer than two free slots. Reset is asynchronous, active low: phase to
// initial, stamps, deadlines, codes and registers to zero.
module thumb_shift_chord_detector
  import tscd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // key_code[15:0], time_now[47:16], shift_held[48]
  input  logic [2:0]           s_axis_tuser,  // action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // char_code[15:0], thumb_code[31:16],
                                              // long_press[32], shift_applied[33]
  output logic [1:0]           m_axis_tuser,  // kind
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  cfg_t       cfg_q;
  logic       item_valid, item_pop, space;
  item_t      item;
  logic [1:0] push_n;
  res_t       push0, push1, out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CHAR_WAIT:  cfg_q.char_wait  <= cfg_data_i;
        REG_THUMB_WAIT: cfg_q.thumb_wait <= cfg_data_i;
        REG_OVERLAP:    cfg_q.overlap    <= cfg_data_i;
        REG_LONG_PRESS: cfg_q.long_press <= cfg_data_i;
        REG_REP_DELAY:  cfg_q.rep_delay  <= cfg_data_i;
        REG_REP_IVAL:   cfg_q.rep_ival   <= cfg_data_i;
        REG_MODE:       cfg_q.mode       <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  tscd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser),
    .key_i        (s_axis_tdata[15:0]),
    .now_i        (s_axis_tdata[47:16]),
    .shift_i      (s_axis_tdata[48]),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  tscd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .space_i      (space),
    .push_n_o     (push_n),
    .push0_o      (push0),
    .push1_o      (push1)
  );

  tscd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (push0),
    .push1_i     (push1),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {6'h0, out.shift_applied, out.long_press, out.thumb_code, out.char_code};
  assign m_axis_tuser = out.kind;
  assign m_axis_tlast = out.last;

endmodule

FILE: design/tscd_front.sv
// Front end: accepts input words, classifies the action and queues items.
// Depends on tscd_pkg.
module tscd_front
  import tscd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] key_i,
  input  logic [31:0] now_i,
  input  logic        shift_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_pop_i
);

  item_t      q_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o   = (cnt_q != 2'd2);
  // unused action codes are dropped here
  assign push         = in_valid_i && in_ready_o && (action_i <= 3'(EV_TICK));
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = item_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= '{ev: ev_e'(action_i), key: key_i, now: now_i, shift: shift_i};
    end
  end

endmodule

FILE: design/tscd_outq.sv
// Result queue: four words, up to two written per cycle, one read per cycle.
// Depends on tscd_pkg.
module tscd_outq
  import tscd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  res_t       push0_i,
  input  res_t       push1_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_o
);

  res_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_o       = mem_q[rd_q];
  assign space_o     = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_q + push_n_i;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_n_i) - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_n_i == 2'd2) mem_q[wr_q + 2'd1] <= push1_i;
  end

endmodule

FILE: design/tscd_back.sv
// Decision engine: the six-phase chord machine, one event per cycle while the result queue has space.
// A tick takes two steps (time-out, then repeat). Depends on tscd_pkg.
module tscd_back
  import tscd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_pop_o,
  input  logic       space_i,
  output logic [1:0] push_n_o,
  output res_t       push0_o,
  output res_t       push1_o
);

  typedef enum logic [2:0] {
    PH_INITIAL   = 3'd0,
    PH_CHAR      = 3'd1,
    PH_RELWAIT   = 3'd2,
    PH_THUMB     = 3'd3,
    PH_CHARTHUMB = 3'd4,
    PH_REPEAT    = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] held_char;
    logic [15:0] held_thumb;
    logic [15:0] rep_char;
    logic [16:0] rep_thumb;   // bit 16: long-press marker
    logic [31:0] char_stamp;
    logic [31:0] thumb_stamp;
    logic [31:0] ev_dl;
    logic [31:0] rep_dl;
  } st_t;

  typedef struct packed {
    st_t        s;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } mach_t;

  localparam logic [16:0] LongMark = 17'h10000;

  function automatic mach_t do_prod(mach_t m_in, logic sh);
    mach_t       m;
    logic [15:0] c;
    logic [16:0] t;
    res_t        r;
    m = m_in;
    c = m.s.held_char;
    t = {1'b0, m.s.held_thumb};
    if (m.s.rep_char != '0 || m.s.rep_thumb != '0) begin
      c = m.s.rep_char;
      t = m.s.rep_thumb;
    end
    m.s.held_char  = '0;
    m.s.held_thumb = '0;
    r = '0;
    if (c == '0 && t != '0) begin
      r.kind       = KIND_THUMB;
      r.thumb_code = t[16] ? 16'h0 : t[15:0];
      r.long_press = t[16];
    end else begin
      r.kind          = (m.s.phase == PH_RELWAIT) ? KIND_BS_CHORD : KIND_CHORD;
      r.char_code     = c;
      r.thumb_code    = t[15:0];
      r.long_press    = t[16];
      r.shift_applied = sh && (t == '0);
    end
    if (m.n == 2'd0) m.r0 = r;
    else m.r1 = r;
    m.n = m.n + 2'd1;
    return m;
  endfunction

  function automatic st_t char_set(st_t s_in, logic [15:0] key, logic [31:0] now,
                                   logic [15:0] wait_ms);
    st_t s;
    s = s_in;
    s.held_char  = key;
    s.char_stamp = now;
    s.ev_dl      = now + {16'h0, wait_ms};
    s.rep_char   = '0;
    s.rep_thumb  = '0;
    return s;
  endfunction

  function automatic st_t thumb_set(st_t s_in, logic [15:0] key, logic [31:0] now,
                                    logic [15:0] wait_ms);
    st_t s;
    s = s_in;
    s.held_thumb  = key;
    s.thumb_stamp = now;
    s.ev_dl       = now + {16'h0, wait_ms};
    s.rep_char    = '0;
    s.rep_thumb   = '0;
    return s;
  endfunction

  function automatic mach_t machine(st_t s_in, ev_e ev, logic [15:0] key,
                                    logic [31:0] now, logic sh, cfg_t c);
    mach_t       m;
    logic [15:0] t;
    logic [31:0] ct_gap, since;
    m     = '0;
    m.s   = s_in;
    t     = m.s.held_thumb;
    ct_gap = m.s.thumb_stamp - m.s.char_stamp;
    since  = now - m.s.thumb_stamp;
    if (ev == EV_ALLOFF) m.s.rep_dl = '0;
    unique case (m.s.phase)
      PH_CHAR: begin
        if (ev == EV_INIT) m.s.phase = PH_INITIAL;
        else if (ev == EV_ALLOFF || ev == EV_REL) begin
          m = do_prod(m, sh);
          m.s.phase = PH_INITIAL;
        end else if (ev == EV_CHAR) begin
          m = do_prod(m, sh);
          m.s = char_set(m.s, key, now, c.char_wait);
        end else if (ev == EV_THUMB) begin
          m.s = thumb_set(m.s, key, now, c.thumb_wait);
          m.s.phase = PH_CHARTHUMB;
        end else if (ev == EV_TIMEOUT) begin
          m.s.rep_char = m.s.held_char;
          m = do_prod(m, sh);
          if (c.mode[1]) begin
            m.s.ev_dl = now + {16'h0, c.long_press};
            m.s.phase = PH_RELWAIT;
          end else begin
            m.s.phase  = PH_REPEAT;
            m.s.rep_dl = now + {16'h0, c.rep_delay};
          end
        end
      end
      PH_RELWAIT: begin
        if (ev == EV_CHAR) begin
          m.s = char_set(m.s, key, now, c.char_wait);
          m.s.phase = PH_CHAR;
        end else if (ev == EV_THUMB) begin
          m.s = thumb_set(m.s, key, now, c.thumb_wait);
          m.s.phase = PH_THUMB;
        end else if (ev == EV_TIMEOUT) begin
          m.s.rep_thumb = LongMark;
          m = do_prod(m, sh);
          m.s.phase  = PH_REPEAT;
          m.s.rep_dl = now + {16'h0, c.rep_delay};
        end else m.s.phase = PH_INITIAL;
      end
      PH_THUMB: begin
        if (ev == EV_INIT) m.s.phase = PH_INITIAL;
        else if (ev == EV_CHAR) begin
          m.s.rep_thumb = {1'b0, m.s.held_thumb};
          m.s.rep_char  = key;
          m = do_prod(m, sh);
          m.s.phase  = PH_REPEAT;
          m.s.rep_dl = now + {16'h0, c.rep_delay};
        end else if (ev == EV_ALLOFF) begin
          m = do_prod(m, sh);
          m.s.phase = PH_INITIAL;
        end else if (ev == EV_REL) begin
          if (key == m.s.held_thumb) begin
            m = do_prod(m, sh);
            m.s.phase = PH_INITIAL;
          end
        end else if (ev == EV_THUMB) begin
          m = do_prod(m, sh);
          m.s = thumb_set(m.s, key, now, c.thumb_wait);
        end else if (ev == EV_TIMEOUT) begin
          if (!c.mode[2]) begin
            m.s.rep_thumb = {1'b0, m.s.held_thumb};
            m = do_prod(m, sh);
            m.s.phase  = PH_REPEAT;
            m.s.rep_dl = now + {16'h0, c.rep_delay};
          end
        end
      end
      PH_CHARTHUMB: begin
        if (ev == EV_INIT) m.s.phase = PH_INITIAL;
        else if (ev == EV_ALLOFF) begin
          m = do_prod(m, sh);
          m.s.phase = PH_INITIAL;
        end else if (ev == EV_THUMB) begin
          m = do_prod(m, sh);
          m.s = thumb_set(m.s, key, now, c.thumb_wait);
          m.s.phase = PH_THUMB;
        end else if (ev == EV_CHAR) begin
          if (ct_gap < since) begin
            m = do_prod(m, sh);
            m.s = char_set(m.s, key, now, c.char_wait);
            m.s.phase = PH_CHAR;
          end else begin
            // character alone first, then the thumb with the new key
            m.s.held_thumb = '0;
            m = do_prod(m, sh);
            m.s.rep_thumb = {1'b0, t};
            m.s.rep_char  = key;
            m = do_prod(m, sh);
            m.s.phase  = PH_REPEAT;
            m.s.rep_dl = now + {16'h0, c.rep_delay};
          end
        end else if (ev == EV_REL) begin
          if (key == m.s.held_char && since < {16'h0, c.overlap} && ct_gap > since) begin
            m.s.held_thumb = '0;
            m = do_prod(m, sh);
            m.s.held_char  = '0;
            m.s.held_thumb = t;
            m.s.phase      = PH_THUMB;
          end else begin
            m = do_prod(m, sh);
            m.s.phase = PH_INITIAL;
          end
        end else if (ev == EV_TIMEOUT) begin
          m.s.rep_thumb = {1'b0, m.s.held_thumb};
          m.s.rep_char  = m.s.held_char;
          m = do_prod(m, sh);
          m.s.phase  = PH_REPEAT;
          m.s.rep_dl = now + {16'h0, c.rep_delay};
        end
      end
      PH_REPEAT: begin
        if (ev == EV_REPEAT) m = do_prod(m, sh);
        else if (ev == EV_THUMB) begin
          m.s = thumb_set(m.s, key, now, c.thumb_wait);
          m.s.held_char = '0;
          m.s.phase = PH_THUMB;
        end else if (ev == EV_CHAR) begin
          m.s = char_set(m.s, key, now, c.char_wait);
          m.s.phase = PH_CHAR;
        end else if (ev != EV_TIMEOUT) m.s.phase = PH_INITIAL;
      end
      default: begin
        m.s = '0;
        if (ev == EV_CHAR) begin
          m.s = char_set(m.s, key, now, c.char_wait);
          m.s.phase = PH_CHAR;
        end else if (ev == EV_THUMB) begin
          m.s = thumb_set(m.s, key, now, c.thumb_wait);
          m.s.phase = PH_THUMB;
        end
      end
    endcase
    return m;
  endfunction

  st_t   s_q, s_d, s_in;
  logic  step_q;
  logic  pend_v_q, pend_v_d;
  res_t  pend_q, pend_d;
  logic  proceed, is_tick, final_step, fire;
  ev_e   ev;
  mach_t m;
  res_t  e [3];
  logic [1:0] k;

  assign is_tick    = (item_i.ev == EV_TICK);
  assign final_step = !is_tick || step_q;
  assign proceed    = item_valid_i && space_i;
  assign item_pop_o = proceed && final_step;

  always_comb begin
    s_in = s_q;
    ev   = item_i.ev;
    fire = 1'b1;
    if (is_tick && !step_q) begin
      fire       = (s_q.ev_dl != '0) && (item_i.now > s_q.ev_dl);
      s_in.ev_dl = '0;
      ev         = EV_TIMEOUT;
    end else if (is_tick) begin
      fire = cfg_i.mode[0] && (s_q.rep_dl != '0) && (item_i.now > s_q.rep_dl);
      ev   = EV_REPEAT;
    end
    m = machine(s_in, ev, item_i.key, item_i.now, item_i.shift, cfg_i);
    if (is_tick && step_q) m.s.rep_dl = item_i.now + {16'h0, cfg_i.rep_ival};
    s_d = fire ? m.s : s_q;

    // line up pending word and new words; on the final step the final one gets last
    e[0] = '0;
    e[1] = '0;
    e[2] = '0;
    k    = 2'd0;
    if (pend_v_q) begin
      e[0] = pend_q;
      k    = 2'd1;
    end
    if (fire && m.n != 2'd0) begin
      e[k] = m.r0;
      k    = k + 2'd1;
    end
    if (fire && m.n == 2'd2) begin
      e[k] = m.r1;
      k    = k + 2'd1;
    end

    push_n_o = 2'd0;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    push0_o  = e[0];
    push1_o  = e[1];
    if (proceed) begin
      if (final_step) begin
        push_n_o = k;
        pend_v_d = 1'b0;
        if (k == 2'd1) push0_o.last = 1'b1;
        if (k == 2'd2) push1_o.last = 1'b1;
      end else if (k != 2'd0) begin
        push_n_o = k - 2'd1;
        pend_v_d = 1'b1;
        pend_d   = e[k - 2'd1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q      <= '0;
      step_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      if (proceed) begin
        s_q    <= s_d;
        step_q <= !final_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

`ifndef SYNTHESIS
  a_pend_only_mid_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> step_q) else $error("pending word outside a tick");
  a_push_has_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_o != 2'd0) |-> space_i) else $error("push without queue space");
  a_event_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && !is_tick) |=> !step_q) else $error("event left a step open");
`endif

endmodule
